FILE: sv/lle_pkg.sv
`timescale 1ns / 1ps

package lle_pkg;

	// store size and result limits
	localparam int DEF_CAPACITY    = 16;
	localparam int DEF_QUEUE_DEPTH = 2;
	localparam int MAX_RESULTS     = 16;
	localparam int SHOW_W          = $clog2(MAX_RESULTS);

	// request codes
	localparam logic [2:0] REQ_INS_FRONT = 3'd0;
	localparam logic [2:0] REQ_INS_BACK  = 3'd1;
	localparam logic [2:0] REQ_DEL_FRONT = 3'd2;
	localparam logic [2:0] REQ_DEL_BACK  = 3'd3;
	localparam logic [2:0] REQ_DEL_POS   = 3'd4;
	localparam logic [2:0] REQ_SHOW      = 3'd5;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_EMPTY   = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	// classified operations handed from front to back
	localparam logic [2:0] OP_ERR       = 3'd0;
	localparam logic [2:0] OP_INS_FRONT = 3'd1;
	localparam logic [2:0] OP_INS_BACK  = 3'd2;
	localparam logic [2:0] OP_DEL       = 3'd3;
	localparam logic [2:0] OP_SHOW      = 3'd4;

	typedef struct packed {
		logic [2:0]         req_type;
		logic signed [31:0] item_value;
		logic [7:0]         position;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] result_value;
		logic               last;
		logic [4:0]         list_length;
	} rsp_t;

	typedef struct packed {
		logic [2:0]         op;
		logic [1:0]         status;
		logic signed [31:0] value;
		logic [7:0]         k;
		logic               was_empty;
		logic [SHOW_W-1:0]  show_last;
		logic [4:0]         len;
	} cmd_t;

endpackage

FILE: sv/lle_ram.sv
`timescale 1ns / 1ps

module lle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, holds while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: sv/lle_front.sv
`timescale 1ns / 1ps

module lle_front
	import lle_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req_word,
	output logic push,
	output cmd_t cmd,
	input  logic full
);

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > 8) ? CW : 8;

	logic [CW-1:0] count_q;
	logic [CW-1:0] count_nxt;

	assign req_stall = full;
	assign push      = req_valid && !full;

	// classify the request against the running entry count
	always_comb begin
		cmd.op        = OP_ERR;
		cmd.status    = ST_INVALID;
		cmd.value     = req_word.item_value;
		cmd.k         = '0;
		cmd.was_empty = (count_q == '0);
		cmd.show_last = '0;
		cmd.len       = 5'(count_q);
		count_nxt     = count_q;
		unique case (req_word.req_type)
			REQ_INS_FRONT, REQ_INS_BACK: begin
				if (count_q == CW'(CAPACITY)) begin
					cmd.status = ST_FULL;
				end else begin
					cmd.op     = (req_word.req_type == REQ_INS_FRONT) ? OP_INS_FRONT
						: OP_INS_BACK;
					cmd.status = ST_OK;
					count_nxt  = CW'(count_q + 1'b1);
					cmd.len    = 5'(count_nxt);
				end
			end
			REQ_DEL_FRONT, REQ_DEL_BACK, REQ_DEL_POS: begin
				if (count_q == '0) begin
					cmd.status = ST_EMPTY;
				end else if (req_word.req_type == REQ_DEL_POS
					&& (req_word.position == '0
					|| CMPW'(req_word.position) > CMPW'(count_q))) begin
					cmd.status = ST_INVALID;
				end else begin
					cmd.op     = OP_DEL;
					cmd.status = ST_OK;
					if (req_word.req_type == REQ_DEL_FRONT) begin
						cmd.k = '0;
					end else if (req_word.req_type == REQ_DEL_BACK) begin
						cmd.k = 8'(count_q - 1'b1);
					end else begin
						cmd.k = req_word.position - 8'd1;
					end
					count_nxt = CW'(count_q - 1'b1);
					cmd.len   = 5'(count_nxt);
				end
			end
			REQ_SHOW: begin
				if (count_q == '0) begin
					cmd.status = ST_EMPTY;
				end else begin
					cmd.op        = OP_SHOW;
					cmd.status    = ST_OK;
					cmd.show_last = (CMPW'(count_q) >= CMPW'(MAX_RESULTS))
						? SHOW_W'(MAX_RESULTS - 1) : SHOW_W'(count_q - 1'b1);
				end
			end
			default: begin
			end
		endcase
	end

	// entry count follows every accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (push) begin
			count_q <= count_nxt;
		end
	end

endmodule

FILE: sv/lle_fifo.sv
`timescale 1ns / 1ps

module lle_fifo
	import lle_pkg::*;
#(
	parameter int DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t din,
	output logic full,
	output logic vld,
	output cmd_t dout,
	input  logic pop
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	cmd_t          slot_q [DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [NW-1:0] cnt_q;

	assign full = (cnt_q == NW'(DEPTH));
	assign vld  = (cnt_q != '0);
	assign dout = slot_q[rptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= din;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : PW'(wptr_q + 1'b1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : PW'(rptr_q + 1'b1);
			end
			if (push && !pop) begin
				cnt_q <= NW'(cnt_q + 1'b1);
			end else if (pop && !push) begin
				cnt_q <= NW'(cnt_q - 1'b1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q < NW'(DEPTH)))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (cnt_q != '0))
		else $error("queue read while empty");

	a_full_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> vld)
		else $error("queue full without a word to read");

endmodule

FILE: sv/lle_back.sv
`timescale 1ns / 1ps

module lle_back
	import lle_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_vld,
	input  cmd_t q_cmd,
	output logic q_pop,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp_word
);

	localparam int SW = $clog2(CAPACITY);

	localparam logic [3:0] S_IDLE       = 4'd0;
	localparam logic [3:0] S_ERR        = 4'd1;
	localparam logic [3:0] S_INS_PUT    = 4'd2;
	localparam logic [3:0] S_DEL_HEAD   = 4'd3;
	localparam logic [3:0] S_DEL_WALK   = 4'd4;
	localparam logic [3:0] S_DEL_UNLINK = 4'd5;
	localparam logic [3:0] S_DEL_FREE   = 4'd6;
	localparam logic [3:0] S_SHOW       = 4'd7;

	logic [3:0]        state_q;
	cmd_t              cmd_q;
	logic [SW-1:0]     head_q;
	logic [SW-1:0]     tail_q;
	logic [SW-1:0]     free_q;
	logic [SW-1:0]     cur_q;
	logic [SW-1:0]     s_q;
	logic [SW-1:0]     walk_q;
	logic [SHOW_W-1:0] show_q;
	logic              lvld_q [CAPACITY];
	logic              lvld_s1;
	logic [SW-1:0]     lra_s1;
	logic              rsp_valid_q;
	rsp_t              rsp_word_q;

	logic              lnk_we;
	logic [SW-1:0]     lnk_wa;
	logic [SW-1:0]     lnk_wd;
	logic              lnk_re;
	logic [SW-1:0]     lnk_ra;
	logic [SW-1:0]     lnk_ram;
	logic [SW-1:0]     lnk_rd;
	logic              val_we;
	logic [SW-1:0]     val_wa;
	logic [31:0]       val_wd;
	logic              val_re;
	logic [SW-1:0]     val_ra;
	logic [31:0]       val_rd;
	logic              out_free;
	logic              emit;
	logic              walk_done;
	logic              show_end;
	rsp_t              emit_word;

	// node value and link stores
	lle_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (val_wa),
		.wdata (val_wd),
		.re    (val_re),
		.raddr (val_ra),
		.rdata (val_rd)
	);

	lle_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_lnk_ram (
		.clk   (clk),
		.we    (lnk_we),
		.waddr (lnk_wa),
		.wdata (lnk_wd),
		.re    (lnk_re),
		.raddr (lnk_ra),
		.rdata (lnk_ram)
	);

	// a never written link still holds the initial free chain
	assign lnk_rd = lvld_s1 ? lnk_ram
		: ((lra_s1 == SW'(CAPACITY - 1)) ? '0 : SW'(lra_s1 + 1'b1));

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign walk_done = (walk_q == cmd_q.k[SW-1:0]);
	assign show_end  = (show_q == cmd_q.show_last);
	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_word_q;

	// store access and result word per state
	always_comb begin
		lnk_we = 1'b0;
		lnk_wa = free_q;
		lnk_wd = free_q;
		lnk_re = 1'b0;
		lnk_ra = head_q;
		val_we = 1'b0;
		val_wa = free_q;
		val_wd = cmd_q.value;
		val_re = 1'b0;
		val_ra = head_q;
		q_pop  = 1'b0;
		emit   = 1'b0;
		emit_word.status       = ST_OK;
		emit_word.result_value = val_rd;
		emit_word.last         = 1'b1;
		emit_word.list_length  = cmd_q.len;
		unique case (state_q)
			S_IDLE: begin
				q_pop = q_vld;
				if (q_vld) begin
					unique case (q_cmd.op)
						OP_INS_FRONT, OP_INS_BACK: begin
							lnk_re = 1'b1;
							lnk_ra = free_q;
						end
						OP_DEL: begin
							lnk_re = 1'b1;
							val_re = (q_cmd.k == '0);
						end
						OP_SHOW: begin
							lnk_re = 1'b1;
							val_re = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			S_ERR: begin
				emit = out_free;
				emit_word.status       = cmd_q.status;
				emit_word.result_value = '0;
			end
			S_INS_PUT: begin
				emit = out_free;
				emit_word.result_value = cmd_q.value;
				val_we = out_free;
				if (!cmd_q.was_empty) begin
					lnk_we = out_free;
					if (cmd_q.op == OP_INS_FRONT) begin
						lnk_wa = free_q;
						lnk_wd = head_q;
					end else begin
						lnk_wa = tail_q;
						lnk_wd = free_q;
					end
				end
			end
			S_DEL_HEAD: begin
			end
			S_DEL_WALK: begin
				lnk_re = 1'b1;
				lnk_ra = lnk_rd;
				val_re = walk_done;
				val_ra = lnk_rd;
			end
			S_DEL_UNLINK: begin
				lnk_we = 1'b1;
				lnk_wa = cur_q;
				lnk_wd = lnk_rd;
			end
			S_DEL_FREE: begin
				emit   = out_free;
				lnk_we = out_free;
				lnk_wa = s_q;
				lnk_wd = free_q;
			end
			S_SHOW: begin
				emit           = out_free;
				emit_word.last = show_end;
				lnk_re         = out_free && !show_end;
				lnk_ra         = lnk_rd;
				val_re         = out_free && !show_end;
				val_ra         = lnk_rd;
			end
			default: begin
			end
		endcase
	end

	// sequencer and list pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			free_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (q_vld) begin
						unique case (q_cmd.op)
							OP_INS_FRONT, OP_INS_BACK: state_q <= S_INS_PUT;
							OP_DEL: state_q <= (q_cmd.k == '0) ? S_DEL_HEAD : S_DEL_WALK;
							OP_SHOW: state_q <= S_SHOW;
							default: state_q <= S_ERR;
						endcase
					end
				end
				S_ERR: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_INS_PUT: begin
					if (out_free) begin
						free_q <= lnk_rd;
						if (cmd_q.was_empty) begin
							head_q <= free_q;
							tail_q <= free_q;
						end else if (cmd_q.op == OP_INS_FRONT) begin
							head_q <= free_q;
						end else begin
							tail_q <= free_q;
						end
						state_q <= S_IDLE;
					end
				end
				S_DEL_HEAD: begin
					head_q  <= lnk_rd;
					state_q <= S_DEL_FREE;
				end
				S_DEL_WALK: begin
					if (walk_done) begin
						state_q <= S_DEL_UNLINK;
					end
				end
				S_DEL_UNLINK: begin
					if (s_q == tail_q) begin
						tail_q <= cur_q;
					end
					state_q <= S_DEL_FREE;
				end
				S_DEL_FREE: begin
					if (out_free) begin
						free_q  <= s_q;
						state_q <= S_IDLE;
					end
				end
				S_SHOW: begin
					if (out_free && show_end) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// working registers of the current command
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && q_vld) begin
			cmd_q  <= q_cmd;
			s_q    <= head_q;
			cur_q  <= head_q;
			walk_q <= SW'(1);
			show_q <= '0;
		end
		if (state_q == S_DEL_WALK) begin
			if (walk_done) begin
				s_q <= lnk_rd;
			end else begin
				cur_q  <= lnk_rd;
				walk_q <= SW'(walk_q + 1'b1);
			end
		end
		if (state_q == S_SHOW && out_free) begin
			show_q <= SHOW_W'(show_q + 1'b1);
		end
	end

	// link written flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CAPACITY; i++) begin
				lvld_q[i] <= 1'b0;
			end
		end else if (lnk_we) begin
			lvld_q[lnk_wa] <= 1'b1;
		end
	end

	// flag and address of the pending link read
	always_ff @(posedge clk) begin
		if (lnk_re) begin
			lvld_s1 <= lvld_q[lnk_ra];
			lra_s1  <= lnk_ra;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_word_q <= emit_word;
		end
	end

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DEL_WALK) |-> (walk_q <= cmd_q.k[SW-1:0]))
		else $error("position walk ran past its target");

	a_free_moves: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(free_q) |->
		($past(state_q) == S_INS_PUT || $past(state_q) == S_DEL_FREE))
		else $error("free chain head moved outside insert or release");

	a_word_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |->
		($past(state_q) == S_ERR || $past(state_q) == S_INS_PUT
		|| $past(state_q) == S_DEL_FREE || $past(state_q) == S_SHOW))
		else $error("result word raised outside a result state");

endmodule

FILE: sv/linked_list_engine_top.sv
`timescale 1ns / 1ps

// linked list engine: ordered list of signed 32-bit values in a node store
// request channel: req_valid, req_stall, req_word (request type, value, position)
// response channel: rsp_valid, rsp_stall, rsp_word (status, value, last, length)
// a word moves at a clock edge with valid high and stall low
// every request gives one response word; display gives one word per entry
// from head to tail, at most 16, with last set on the final one
// the front classifies requests and keeps the entry count, then queues them;
// the back walks the link store one node per cycle, but during display
// only while the response word is not stalled
// the link store has a single read port
// the queue lets requests enter while the back is busy
// reset clears the list, rebuilds the free chain and empties the queue
// while rsp_stall is high a pending word holds; the back waits to emit more
module linked_list_engine_top
	import lle_pkg::*;
#(
	parameter int CAPACITY    = DEF_CAPACITY,
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req_word,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp_word
);

	logic push;
	logic full;
	logic q_vld;
	logic q_pop;
	cmd_t f_cmd;
	cmd_t q_cmd;

	// classify and count
	lle_front #(.CAPACITY(CAPACITY)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_word  (req_word),
		.push      (push),
		.cmd       (f_cmd),
		.full      (full)
	);

	// command queue between front and back
	lle_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (f_cmd),
		.full   (full),
		.vld    (q_vld),
		.dout   (q_cmd),
		.pop    (q_pop)
	);

	// list walker and store
	lle_back #(.CAPACITY(CAPACITY)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_vld     (q_vld),
		.q_cmd     (q_cmd),
		.q_pop     (q_pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_word  (rsp_word)
	);

endmodule
